### rtl/core/ole_pkg.sv
// ole_pkg: shared constants, codes, types and word helpers of the ordered list engine
// no dependencies; imported by every other file of the block

package ole_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int OPCODE_W = 4;
  localparam int FIELD_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PREPEND    = 4'd0,
    OP_APPEND     = 4'd1,
    OP_DEL_VALUE  = 4'd2,
    OP_GET        = 4'd3,
    OP_INS_BEFORE = 4'd4,
    OP_INS_AFTER  = 4'd5,
    OP_CONTAINS   = 4'd6,
    OP_DEL_FRONT  = 4'd7,
    OP_DEL_BACK   = 4'd8
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_EMPTY        = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_PREPEND,
    ACT_APPEND,
    ACT_DEL_FRONT,
    ACT_DEL_AT,
    ACT_INS_BEFORE,
    ACT_INS_AFTER
  } act_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  typedef struct packed {
    act_t             action;
    word_t            key;
    word_t            item;
    logic [LEN_W-1:0] len;
  } cell_cmd_t;

  typedef struct packed {
    logic pre;
    logic first;
    logic seen;
  } link_t;

  function automatic word_t to_word(input logic [FIELD_W-1:0] v);
    logic signed [63:0] e;
    e = 64'(signed'(v));
    return e[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] word_out(input word_t w);
    logic signed [63:0] e;
    e = 64'(signed'(w));
    return e[FIELD_W-1:0];
  endfunction

endpackage

### rtl/core/ole_if.sv
// ole_if: request and response channel interfaces of the ordered list engine
// depends on ole_pkg for field widths

interface ole_req_if;
  import ole_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [FIELD_W-1:0]  item_value;
  logic [FIELD_W-1:0]  target_value;
  logic [POS_W-1:0]    position;

  modport source (output valid, opcode, item_value, target_value, position, input ready);
  modport sink   (input valid, opcode, item_value, target_value, position, output ready);
endinterface

interface ole_rsp_if;
  import ole_pkg::*;
  logic                valid;
  logic                ready;
  logic [FIELD_W-1:0]  read_data;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, read_data, status, entry_count, input ready);
  modport sink   (input valid, read_data, status, entry_count, output ready);
endinterface

### rtl/core/ole_cell.sv
// ole_cell: one list position; holds a word, compares it with the key and
// passes its match flags and word to its neighbors; depends on ole_pkg

module ole_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ole_pkg::IDX_W-1:0] cell_index,
  input  ole_pkg::cell_cmd_t       cmd,
  input  ole_pkg::word_t           left_word,
  input  ole_pkg::word_t           right_word,
  input  ole_pkg::link_t           left_link,
  output ole_pkg::link_t           link_out,
  output ole_pkg::word_t           word
);
  import ole_pkg::*;

  logic  pre;
  logic  in_range;
  logic  match;
  logic  first;
  word_t word_next;

  assign in_range = LEN_W'(cell_index) < cmd.len;
  assign match    = in_range && (word == cmd.key);
  assign first    = match && !pre;

  assign link_out.pre   = pre;
  assign link_out.first = first;
  assign link_out.seen  = pre || match;

  always_comb begin
    word_next = word;
    unique case (cmd.action)
      ACT_HOLD:       word_next = word;
      ACT_PREPEND:    word_next = (cell_index == '0) ? cmd.item : left_word;
      ACT_APPEND:     if (LEN_W'(cell_index) == cmd.len) word_next = cmd.item;
      ACT_DEL_FRONT:  word_next = right_word;
      ACT_DEL_AT:     if (pre || match) word_next = right_word;
      ACT_INS_BEFORE: begin
        if (first) word_next = cmd.item;
        else if (pre) word_next = left_word;
      end
      ACT_INS_AFTER: begin
        if (left_link.first) word_next = cmd.item;
        else if (left_link.pre) word_next = left_word;
      end
      default:        word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre <= 1'b0;
    end else begin
      pre <= left_link.seen;
    end
    word <= word_next;
  end

endmodule

### rtl/core/ole_ctrl.sv
// ole_ctrl: request register, scan sequencer, result decision and response register
// depends on ole_pkg; drives the command bus of the cell chain

module ole_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [ole_pkg::OPCODE_W-1:0] req_opcode,
  input  logic [ole_pkg::FIELD_W-1:0]  req_item,
  input  logic [ole_pkg::FIELD_W-1:0]  req_target,
  input  logic [ole_pkg::POS_W-1:0]    req_position,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [ole_pkg::FIELD_W-1:0]  rsp_data,
  output logic [ole_pkg::STATUS_W-1:0] rsp_status,
  output logic [ole_pkg::COUNT_W-1:0]  rsp_count,
  output ole_pkg::cell_cmd_t           cmd,
  output logic [ole_pkg::IDX_W-1:0]    rd_index,
  input  ole_pkg::word_t               rd_word,
  input  logic                         found
);
  import ole_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [IDX_W-1:0]     cnt;
  logic [OPCODE_W-1:0]  op;
  word_t                key;
  word_t                item;
  logic [POS_W-1:0]     pos;
  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     len_next;
  act_t                 act;
  status_t              st;
  logic [FIELD_W-1:0]   data;
  logic                 req_fire;
  logic                 exec_fire;
  logic                 is_search;
  logic                 is_ins;
  logic                 full;
  logic                 empty;
  logic                 pos_ok;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign exec_fire = (state == S_EXEC) && (!rsp_valid || rsp_ready);
  assign is_ins    = (req_opcode == OP_INS_BEFORE) || (req_opcode == OP_INS_AFTER);
  assign is_search = is_ins || (req_opcode == OP_DEL_VALUE) || (req_opcode == OP_CONTAINS);
  assign full      = (len == LEN_W'(DEPTH));
  assign empty     = (len == '0);
  assign pos_ok    = CMP_W'(pos) < CMP_W'(len);
  assign rd_index  = IDX_W'(pos);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_fire) state_next = is_search ? S_SCAN : S_EXEC;
      S_SCAN: if (cnt == IDX_W'(DEPTH - 1)) state_next = S_EXEC;
      S_EXEC: if (exec_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    act      = ACT_HOLD;
    st       = ST_OK;
    data     = '0;
    len_next = len;
    unique case (op)
      OP_PREPEND, OP_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          act      = (op == OP_PREPEND) ? ACT_PREPEND : ACT_APPEND;
          len_next = len + LEN_W'(1);
        end
      end
      OP_DEL_VALUE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (!found) begin
          st = ST_NOT_FOUND;
        end else begin
          act      = ACT_DEL_AT;
          len_next = len - LEN_W'(1);
        end
      end
      OP_GET: begin
        if (pos_ok) begin
          data = word_out(rd_word);
        end else begin
          data = '1;
          st   = ST_OUT_OF_RANGE;
        end
      end
      OP_INS_BEFORE, OP_INS_AFTER: begin
        if (!found) begin
          st = ST_NOT_FOUND;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          act      = (op == OP_INS_BEFORE) ? ACT_INS_BEFORE : ACT_INS_AFTER;
          len_next = len + LEN_W'(1);
        end
      end
      OP_CONTAINS: if (!found) st = ST_NOT_FOUND;
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          act      = (op == OP_DEL_FRONT) ? ACT_DEL_FRONT : ACT_HOLD;
          len_next = len - LEN_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign cmd.action = exec_fire ? act : ACT_HOLD;
  assign cmd.key    = key;
  assign cmd.item   = item;
  assign cmd.len    = len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      len       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state == S_SCAN) ? cnt + IDX_W'(1) : '0;
      if (exec_fire) begin
        len       <= len_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (req_fire) begin
      op   <= req_opcode;
      key  <= to_word(is_ins ? req_target : req_item);
      item <= to_word(req_item);
      pos  <= req_position;
    end
    if (exec_fire) begin
      rsp_data   <= data;
      rsp_status <= st;
      rsp_count  <= COUNT_W'(len_next);
    end
  end

endmodule

### rtl/core/ordered_list_engine.sv
// ordered_list_engine: top level; a chain of DEPTH list cells driven by one sequencer
// depends on ole_pkg, ole_if, ole_cell and ole_ctrl
// searching requests (delete by value, insert before/after, contains) pass through a scan
// state in which the match flags ripple one cell per cycle, then the execute state registers
// the result; other requests go straight from accept to the execute state, which waits while
// a response is stalled; a new request waits until the last is done; reset clears count and control

module ordered_list_engine (
  input  logic             clk,
  input  logic             rst,
  ole_req_if.sink          req,
  ole_rsp_if.source        rsp
);
  import ole_pkg::*;

  cell_cmd_t        cmd;
  word_t            words [DEPTH];
  link_t            links [DEPTH];
  logic [IDX_W-1:0] rd_index;

  ole_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_opcode   (req.opcode),
    .req_item     (req.item_value),
    .req_target   (req.target_value),
    .req_position (req.position),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_data     (rsp.read_data),
    .rsp_status   (rsp.status),
    .rsp_count    (rsp.entry_count),
    .cmd          (cmd),
    .rd_index     (rd_index),
    .rd_word      (words[rd_index]),
    .found        (links[DEPTH-1].seen)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_word;
    word_t right_word;
    link_t left_link;

    if (i == 0) begin : g_first
      assign left_word = '0;
      assign left_link = '0;
    end else begin : g_mid
      assign left_word = words[i-1];
      assign left_link = links[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_body
      assign right_word = words[i+1];
    end

    ole_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .cmd        (cmd),
      .left_word  (left_word),
      .right_word (right_word),
      .left_link  (left_link),
      .link_out   (links[i]),
      .word       (words[i])
    );
  end

endmodule

### rtl/core/ole_checker.sv
// ole_checker: response-side checks of the ordered list engine, bound to the top level
// depends on ole_pkg and ordered_list_engine

module ole_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [ole_pkg::FIELD_W-1:0]  read_data,
  input logic [ole_pkg::STATUS_W-1:0] status,
  input logic [ole_pkg::COUNT_W-1:0]  entry_count
);
  import ole_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(status)
      && $stable(entry_count))
    else $error("response changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entry_count <= COUNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> entry_count == COUNT_W'(DEPTH))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_EMPTY |-> entry_count == '0)
    else $error("empty status with entries present");

  a_oor_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_OUT_OF_RANGE |-> read_data == '1)
    else $error("out of range read without all-ones data");

endmodule

bind ordered_list_engine ole_checker u_ole_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .read_data   (rsp.read_data),
  .status      (rsp.status),
  .entry_count (rsp.entry_count)
);
